// ===== rtl/slt_pkg.sv =====
package slt_pkg;

    localparam int CAPACITY   = 32;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int OCC_BITS   = $clog2(CAPACITY + 1);

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_DUMP   = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic KIND_LISTED  = 1'b0;
    localparam logic KIND_DROPPED = 1'b1;

    localparam logic [OCC_BITS-1:0] OCC_FULL = OCC_BITS'(CAPACITY);

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [ADDR_BITS-1:0]  t_addr;
    typedef logic [OCC_BITS-1:0]   t_occ;

    typedef struct packed {
        logic   we;
        t_addr  waddr;
        t_value wdata;
        t_addr  raddr;
    } t_mem_req;

endpackage

// ===== rtl/sorted_list_table_top.sv =====
// Sorted list table: entries in one single-port-write RAM, sequenced one entry per cycle.
// Insert: done in idle when empty or full (drop result strobed the cycle after), else entries moved up, then written.
// Remove: does nothing when empty, else scans to the match, then closes the gap.
// Dump: each entry passes the RAM read register and the output register; results then follow one per cycle.
// Results are strobed for one cycle; the receiver cannot stall.
// Synchronous active-low reset empties the list; RAM contents are not cleared.
module sorted_list_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_operand,
    output logic        o_valid,
    output logic        o_kind,
    output logic [31:0] o_element,
    output logic        o_last
);
    import slt_pkg::*;

    t_mem_req mem;
    t_value   rdata;

    slt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_action  (i_action),
        .i_operand (i_operand),
        .o_busy    (busy),
        .o_mem     (mem),
        .i_rdata   (rdata),
        .o_valid   (o_valid),
        .o_kind    (o_kind),
        .o_element (o_element),
        .o_last    (o_last)
    );

    slt_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

endmodule

// ===== rtl/slt_ram.sv =====
module slt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/slt_ctrl.sv =====
module slt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_action,
    input  logic [31:0]       i_operand,
    output logic              o_busy,
    output slt_pkg::t_mem_req o_mem,
    input  slt_pkg::t_value   i_rdata,
    output logic              o_valid,
    output logic              o_kind,
    output logic [31:0]       o_element,
    output logic              o_last
);
    import slt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_SCAN,
        S_SHIFT,
        S_DUMP
    } t_state;

    t_state r_state, n_state;
    t_addr  r_idx, n_idx;
    t_occ   r_occ, n_occ;
    t_value r_val, n_val;
    logic   r_valid, n_valid;
    logic   r_kind, n_kind;
    t_value r_elem, n_elem;
    logic   r_last, n_last;

    t_value   in_val;
    t_addr    idx_p1;
    t_occ     idx_p1_occ;
    t_occ     idx_p2_occ;
    t_mem_req mem;

    assign in_val     = i_operand[VALUE_BITS-1:0];
    assign idx_p1     = r_idx + ADDR_BITS'(1);
    assign idx_p1_occ = OCC_BITS'(r_idx) + OCC_BITS'(1);
    assign idx_p2_occ = OCC_BITS'(r_idx) + OCC_BITS'(2);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_occ     = r_occ;
        n_val     = r_val;
        n_valid   = 1'b0;
        n_kind    = r_kind;
        n_elem    = r_elem;
        n_last    = r_last;
        mem.we    = 1'b0;
        mem.waddr = r_idx;
        mem.wdata = r_val;
        mem.raddr = idx_p1;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_action)
                        ACT_INSERT: begin
                            if (r_occ == OCC_FULL) begin
                                n_valid = 1'b1;
                                n_kind  = KIND_DROPPED;
                                n_elem  = in_val;
                                n_last  = 1'b1;
                            end else if (r_occ == '0) begin
                                mem.we    = 1'b1;
                                mem.waddr = '0;
                                mem.wdata = in_val;
                                n_occ     = OCC_BITS'(1);
                            end else begin
                                mem.raddr = ADDR_BITS'(r_occ - OCC_BITS'(1));
                                n_idx     = ADDR_BITS'(r_occ - OCC_BITS'(1));
                                n_val     = in_val;
                                n_state   = S_INS;
                            end
                        end
                        ACT_REMOVE: begin
                            if (r_occ != '0) begin
                                mem.raddr = '0;
                                n_idx     = '0;
                                n_val     = in_val;
                                n_state   = S_SCAN;
                            end
                        end
                        ACT_DUMP: begin
                            if (r_occ != '0) begin
                                mem.raddr = '0;
                                n_idx     = '0;
                                n_state   = S_DUMP;
                            end
                        end
                        ACT_CLEAR: begin
                            n_occ = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS: begin
                mem.we    = 1'b1;
                mem.waddr = idx_p1;
                if ($signed(i_rdata) > $signed(r_val)) begin
                    mem.wdata = i_rdata;
                    if (r_idx == '0) begin
                        n_state = S_PUT;
                    end else begin
                        mem.raddr = r_idx - ADDR_BITS'(1);
                        n_idx     = r_idx - ADDR_BITS'(1);
                    end
                end else begin
                    mem.wdata = r_val;
                    n_occ     = r_occ + OCC_BITS'(1);
                    n_state   = S_IDLE;
                end
            end
            S_PUT: begin
                mem.we    = 1'b1;
                mem.waddr = r_idx;
                mem.wdata = r_val;
                n_occ     = r_occ + OCC_BITS'(1);
                n_state   = S_IDLE;
            end
            S_SCAN: begin
                if (i_rdata == r_val) begin
                    if (idx_p1_occ == r_occ) begin
                        n_occ   = r_occ - OCC_BITS'(1);
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (idx_p1_occ == r_occ) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = idx_p1;
                end
            end
            S_SHIFT: begin
                // entry idx+1 moves up to idx
                mem.we    = 1'b1;
                mem.waddr = r_idx;
                mem.wdata = i_rdata;
                mem.raddr = r_idx + ADDR_BITS'(2);
                n_idx     = idx_p1;
                if (idx_p2_occ == r_occ) begin
                    n_occ   = r_occ - OCC_BITS'(1);
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                n_valid = 1'b1;
                n_kind  = KIND_LISTED;
                n_elem  = i_rdata;
                n_last  = (idx_p1_occ == r_occ);
                if (idx_p1_occ == r_occ) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = idx_p1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_valid <= n_valid;
        end
        r_idx  <= n_idx;
        r_val  <= n_val;
        r_kind <= n_kind;
        r_elem <= n_elem;
        r_last <= n_last;
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_mem     = mem;
    assign o_valid   = r_valid;
    assign o_kind    = r_kind;
    assign o_element = 32'(r_elem);
    assign o_last    = r_last;

endmodule
